// ===== rtl/suii_pkg.sv =====
package suii_pkg;

   // default sizing of the row
   localparam int MAX_ENTRIES_DEFAULT = 64;
   localparam int INDEX_WIDTH_DEFAULT = 32;

   // fixed field widths on the ports
   localparam int MODE_WIDTH     = 2;
   localparam int COLUMN_WIDTH   = 32;
   localparam int POSITION_WIDTH = 6;
   localparam int STATUS_WIDTH   = 3;
   localparam int VALUE_WIDTH    = 32;
   localparam int COUNT_WIDTH    = 7;
   localparam int SLOT_WIDTH     = 6;

   // request modes
   localparam logic [MODE_WIDTH-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_READ   = 2'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_CLEAR  = 2'd2;
   localparam logic [MODE_WIDTH-1:0] MODE_NONE   = 2'd3;

   // response status codes
   localparam logic [STATUS_WIDTH-1:0] STATUS_INSERTED  = 3'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_DUPLICATE = 3'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_FULL      = 3'd2;
   localparam logic [STATUS_WIDTH-1:0] STATUS_READ_OK   = 3'd3;
   localparam logic [STATUS_WIDTH-1:0] STATUS_READ_OOR  = 3'd4;
   localparam logic [STATUS_WIDTH-1:0] STATUS_CLEARED   = 3'd5;

   // broadcast control from the sequencer to every cell
   typedef struct packed {
      logic compare;   // latch compare flags against the broadcast column
      logic insert;    // shift up and drop the column in at the boundary
   } cell_ctrl_type;

endpackage

// ===== rtl/suii_cell.sv =====
module suii_cell #(
   parameter int INDEX_WIDTH = suii_pkg::INDEX_WIDTH_DEFAULT,
   parameter int CNT_WIDTH   = 7,
   parameter int CELL_INDEX  = 0
) (
   input  logic                                clock,
   input  suii_pkg::cell_ctrl_type             ctrl,
   input  logic [INDEX_WIDTH-1:0]              col,
   input  logic [suii_pkg::POSITION_WIDTH-1:0] position,
   input  logic [CNT_WIDTH-1:0]                count,
   input  logic [INDEX_WIDTH-1:0]              left_entry,
   input  logic                                left_lt,
   output logic [INDEX_WIDTH-1:0]              entry,
   output logic                                lt,
   output logic                                eq,
   output logic                                hit
);

   localparam int CMP_WIDTH = (CNT_WIDTH > suii_pkg::POSITION_WIDTH) ?
                              CNT_WIDTH : suii_pkg::POSITION_WIDTH;
   localparam logic [CNT_WIDTH-1:0] MY_INDEX = CNT_WIDTH'(CELL_INDEX);
   localparam logic [CMP_WIDTH-1:0] MY_POS   = CMP_WIDTH'(CELL_INDEX);

   logic [INDEX_WIDTH-1:0] entry_ff;
   logic [INDEX_WIDTH-1:0] entry_in;
   logic                   lt_ff;
   logic                   eq_ff;
   logic                   hit_ff;
   logic                   held;
   logic                   less;
   logic                   same;
   logic                   at_pos;

   // cell holds a live entry when it sits below the fill count
   assign held   = MY_INDEX < count;
   assign less   = $signed(entry_ff) < $signed(col);
   assign same   = entry_ff == col;
   assign at_pos = CMP_WIDTH'(position) == MY_POS;

   // cells at or above the boundary take the left neighbor, the boundary takes the column
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.insert && !lt_ff) begin
         entry_in = left_lt ? col : left_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (ctrl.compare) begin
         lt_ff  <= held & less;
         eq_ff  <= held & same;
         hit_ff <= held & at_pos;
      end
   end

   assign entry = entry_ff;
   assign lt    = lt_ff;
   assign eq    = eq_ff;
   assign hit   = hit_ff;

endmodule

// ===== rtl/sorted_unique_index_insert_unit.sv =====
// Sorted unique column-index list for one sparse-matrix row, kept in a row of
// MAX_ENTRIES compare-and-shift cells. Insert words place a column at its ascending
// (signed) position or report it as a duplicate or as dropped when the row is full;
// read words return the entry at a position; clear words empty the row. Each word
// passes a compare state, where every cell compares against the broadcast column,
// then an update state, where the row shifts up by one cell behind the insert point
// and the response is registered. A new word is taken in the update state while
// responses are taken; a held response stalls the update state. A word with the
// unused mode is taken without entering either state and gives no response.
// Entries are valid only below the fill count; no clearing pass is needed.
module sorted_unique_index_insert_unit #(
   parameter int MAX_ENTRIES = suii_pkg::MAX_ENTRIES_DEFAULT,
   parameter int INDEX_WIDTH = suii_pkg::INDEX_WIDTH_DEFAULT
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_ready,
   input  logic [suii_pkg::MODE_WIDTH-1:0]            req_mode,
   input  logic signed [suii_pkg::COLUMN_WIDTH-1:0]   req_column,
   input  logic [suii_pkg::POSITION_WIDTH-1:0]        req_position,
   input  logic                                       req_batch_last,
   output logic                                       rsp_valid,
   input  logic                                       rsp_ready,
   output logic [suii_pkg::STATUS_WIDTH-1:0]          rsp_status,
   output logic signed [suii_pkg::VALUE_WIDTH-1:0]    rsp_read_value,
   output logic [suii_pkg::COUNT_WIDTH-1:0]           rsp_entry_count,
   output logic [suii_pkg::SLOT_WIDTH-1:0]            rsp_insert_slot,
   output logic                                       rsp_batch_done
);

   localparam int CNT_WIDTH  = $clog2(MAX_ENTRIES + 1);
   localparam int SLOT_BITS  = $clog2(MAX_ENTRIES);
   localparam logic [CNT_WIDTH-1:0] FULL_COUNT = CNT_WIDTH'(MAX_ENTRIES);
   localparam logic [CNT_WIDTH-1:0] ONE_COUNT  = CNT_WIDTH'(1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_UPDATE
   } state_type;

   state_type                              state_ff;
   logic [CNT_WIDTH-1:0]                   count_ff;
   logic [suii_pkg::MODE_WIDTH-1:0]        mode_ff;
   logic [INDEX_WIDTH-1:0]                 col_ff;
   logic [suii_pkg::POSITION_WIDTH-1:0]    pos_ff;
   logic                                   last_ff;

   logic                                   rsp_valid_ff;
   logic [suii_pkg::STATUS_WIDTH-1:0]      rsp_status_ff;
   logic [suii_pkg::VALUE_WIDTH-1:0]       rsp_value_ff;
   logic [suii_pkg::COUNT_WIDTH-1:0]       rsp_count_ff;
   logic [suii_pkg::SLOT_WIDTH-1:0]        rsp_slot_ff;
   logic                                   rsp_last_ff;

   logic [suii_pkg::STATUS_WIDTH-1:0]      status_in;
   logic [suii_pkg::VALUE_WIDTH-1:0]       value_in;
   logic [CNT_WIDTH-1:0]                   count_in;
   logic [SLOT_BITS-1:0]                   slot_in;

   suii_pkg::cell_ctrl_type                ctrl;
   logic [INDEX_WIDTH-1:0]                 cell_entry [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0]                 cell_lt;
   logic [MAX_ENTRIES-1:0]                 cell_eq;
   logic [MAX_ENTRIES-1:0]                 cell_hit;
   logic [MAX_ENTRIES-1:0]                 boundary;
   logic [SLOT_BITS-1:0]                   slot_term [MAX_ENTRIES];

   logic out_free;
   logic req_fire;
   logic finish;
   logic dup;
   logic full;
   logic read_hit;
   logic [INDEX_WIDTH-1:0]                 read_entry;
   logic [SLOT_BITS-1:0]                   slot;

   // handshake
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign finish    = (state_ff == ST_UPDATE) && out_free;
   assign req_ready = (state_ff == ST_IDLE) || finish;
   assign req_fire  = req_valid && req_ready;

   // broadcast control to the row
   assign dup  = |cell_eq;
   assign full = count_ff == FULL_COUNT;
   assign ctrl.compare = state_ff == ST_COMPARE;
   assign ctrl.insert  = finish && (mode_ff == suii_pkg::MODE_INSERT) && !dup && !full;

   // row of cells
   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      logic [INDEX_WIDTH-1:0] left_entry;
      logic                   left_lt;

      if (i == 0) begin : g_first
         assign left_entry = '0;
         assign left_lt    = 1'b1;
      end else begin : g_rest
         assign left_entry = cell_entry[i-1];
         assign left_lt    = cell_lt[i-1];
      end

      suii_cell #(
         .INDEX_WIDTH (INDEX_WIDTH),
         .CNT_WIDTH   (CNT_WIDTH),
         .CELL_INDEX  (i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .col        (col_ff),
         .position   (pos_ff),
         .count      (count_ff),
         .left_entry (left_entry),
         .left_lt    (left_lt),
         .entry      (cell_entry[i]),
         .lt         (cell_lt[i]),
         .eq         (cell_eq[i]),
         .hit        (cell_hit[i])
      );

      // first cell not below the column marks the sorted slot
      assign boundary[i]  = !cell_lt[i] && left_lt;
      assign slot_term[i] = boundary[i] ? SLOT_BITS'(i) : '0;
   end

   // fold slot index and read data across the row
   always_comb begin
      slot       = '0;
      read_entry = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         slot       = slot | slot_term[i];
         read_entry = read_entry | (cell_hit[i] ? cell_entry[i] : '0);
      end
   end
   assign read_hit = |cell_hit;

   // response and next count
   always_comb begin
      status_in = suii_pkg::STATUS_CLEARED;
      value_in  = '0;
      count_in  = count_ff;
      slot_in   = '0;
      case (mode_ff)
         suii_pkg::MODE_INSERT: begin
            if (dup) begin
               status_in = suii_pkg::STATUS_DUPLICATE;
               slot_in   = slot;
            end else if (full) begin
               status_in = suii_pkg::STATUS_FULL;
            end else begin
               status_in = suii_pkg::STATUS_INSERTED;
               slot_in   = slot;
               count_in  = count_ff + ONE_COUNT;
            end
         end
         suii_pkg::MODE_READ: begin
            if (read_hit) begin
               status_in = suii_pkg::STATUS_READ_OK;
               value_in  = suii_pkg::VALUE_WIDTH'(read_entry);
            end else begin
               status_in = suii_pkg::STATUS_READ_OOR;
            end
         end
         default: begin
            status_in = suii_pkg::STATUS_CLEARED;
            count_in  = '0;
         end
      endcase
   end

   // sequencer, request latch and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (finish) begin
            count_ff      <= count_in;
            rsp_valid_ff  <= 1'b1;
            rsp_status_ff <= status_in;
            rsp_value_ff  <= value_in;
            rsp_count_ff  <= suii_pkg::COUNT_WIDTH'(count_in);
            rsp_slot_ff   <= suii_pkg::SLOT_WIDTH'(slot_in);
            rsp_last_ff   <= last_ff;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire && req_mode != suii_pkg::MODE_NONE) begin
                  state_ff <= ST_COMPARE;
               end
            end
            ST_COMPARE: begin
               state_ff <= ST_UPDATE;
            end
            ST_UPDATE: begin
               if (finish) begin
                  state_ff <= (req_fire && req_mode != suii_pkg::MODE_NONE) ?
                              ST_COMPARE : ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end

      if (req_fire) begin
         mode_ff <= req_mode;
         col_ff  <= INDEX_WIDTH'($unsigned(req_column));
         pos_ff  <= req_position;
         last_ff <= req_batch_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_read_value  = $signed(rsp_value_ff);
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_insert_slot = rsp_slot_ff;
   assign rsp_batch_done  = rsp_last_ff;

   // fill count never passes the row length
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("fill count above row length");

   // a sorted row has at most one insert boundary
   a_one_boundary: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |-> $onehot0(boundary))
      else $error("more than one insert boundary in the row");

   // a new response only follows the update cycle
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_UPDATE))
      else $error("response raised outside the update cycle");

   // a clear response reports an empty row
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      (finish && mode_ff == suii_pkg::MODE_CLEAR) |=> (rsp_count_ff == '0))
      else $error("clear left entries in the row");

endmodule
